// File: hw/rtl/mmh_pkg.sv
// mmh_pkg: constants, command types and helpers for the murmur2 stream hash
// used by mmh_ctrl, mmh_dpath and murmur2_stream_hash; no dependencies
`default_nettype none

package mmh_pkg;

    localparam logic [31:0] MixMult   = 32'h5bd1_e995;
    localparam int unsigned MixShift  = 24;
    localparam int unsigned FinShiftA = 13;
    localparam int unsigned FinShiftB = 15;
    localparam logic [31:0] SeedReset = 32'h3141_5926;

    // datapath operation for the current cycle
    typedef enum logic [2:0] {
        OP_NONE,
        OP_K1,
        OP_K2,
        OP_HFULL,
        OP_HTAIL,
        OP_FIN,
        OP_EMIT
    } t_op;

    typedef struct packed {
        logic load;
        t_op  op;
    } t_cmd;

    function automatic logic [31:0] tail_mask(input logic [1:0] count);
        logic [31:0] m;
        unique case (count)
            2'd1:    m = 32'h0000_00ff;
            2'd2:    m = 32'h0000_ffff;
            2'd3:    m = 32'h00ff_ffff;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mmh_dpath.sv
// mmh_dpath: hash datapath with one shared multiply-by-constant unit,
// seed register and result register; depends on mmh_pkg
`default_nettype none

module mmh_dpath import mmh_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic [31:0] i_data_word,
    input  wire logic [2:0]  i_byte_count,
    input  wire logic        i_is_first,
    input  wire logic [31:0] i_key_length,
    output logic [31:0]      o_hash_value
);

    logic [31:0] r_seed;
    logic [31:0] r_hash;
    logic [31:0] r_word;
    logic [31:0] r_k;
    logic [31:0] r_out;
    logic [31:0] mul_a;
    logic [31:0] mul_p;
    logic [31:0] fin_h;

    always_comb begin
        unique case (i_cmd.op)
            OP_K1:    mul_a = r_word;
            OP_K2:    mul_a = r_k ^ (r_k >> MixShift);
            OP_HFULL: mul_a = r_hash;
            OP_HTAIL: mul_a = r_hash ^ r_word;
            OP_FIN:   mul_a = r_hash ^ (r_hash >> FinShiftA);
            default:  mul_a = r_hash;
        endcase
    end

    // low 32 bits only: arithmetic is modulo 2^32
    assign mul_p = 32'(mul_a * MixMult);
    assign fin_h = r_hash ^ (r_hash >> FinShiftB);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SeedReset;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
        end else if (i_cmd.load) begin
            if (i_is_first) begin
                r_hash <= r_seed ^ i_key_length;
            end
        end else begin
            unique case (i_cmd.op)
                OP_HFULL:        r_hash <= mul_p ^ r_k;
                OP_HTAIL, OP_FIN: r_hash <= mul_p;
                OP_EMIT:         r_hash <= fin_h;
                default:         r_hash <= r_hash;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            // partial words are masked once here
            r_word <= i_byte_count[2] ? i_data_word
                                      : (i_data_word & tail_mask(i_byte_count[1:0]));
        end
        if (i_cmd.op == OP_K1 || i_cmd.op == OP_K2) begin
            r_k <= mul_p;
        end
        if (i_cmd.op == OP_EMIT) begin
            r_out <= fin_h;
        end
    end

    assign o_hash_value = r_out;

endmodule

`default_nettype wire

// File: hw/rtl/mmh_ctrl.sv
// mmh_ctrl: sequencer for one item at a time and the result beat valid flag
// depends on mmh_pkg
`default_nettype none

module mmh_ctrl import mmh_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [2:0] i_byte_count,
    input  wire logic       i_is_last,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_cmd            o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_K1,
        S_K2,
        S_HFULL,
        S_HTAIL,
        S_FIN,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_last;
    logic   r_out_valid;
    logic   accept;
    logic   out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd.load = accept;
        unique case (r_state)
            S_K1:    o_cmd.op = OP_K1;
            S_K2:    o_cmd.op = OP_K2;
            S_HFULL: o_cmd.op = OP_HFULL;
            S_HTAIL: o_cmd.op = OP_HTAIL;
            S_FIN:   o_cmd.op = OP_FIN;
            S_EMIT:  o_cmd.op = out_free ? OP_EMIT : OP_NONE;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_last <= i_is_last;
                        // counts 5..7 saturate to a full word
                        if (i_byte_count[2]) begin
                            r_state <= S_K1;
                        end else if (i_byte_count[1:0] != 2'd0) begin
                            r_state <= S_HTAIL;
                        end else if (i_is_last) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_K1:    r_state <= S_K2;
                S_K2:    r_state <= S_HFULL;
                S_HFULL: r_state <= r_last ? S_FIN : S_IDLE;
                S_HTAIL: r_state <= r_last ? S_FIN : S_IDLE;
                S_FIN:   r_state <= S_EMIT;
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: hw/rtl/murmur2_stream_hash.sv
// murmur2_stream_hash: 32-bit murmurhash2 over little-endian key words
// one item at a time through a shared multiply unit; the beat is taken in idle,
// then a full word steps through K1, K2 and HFULL, a tail through HTAIL, an empty item
// through none; a last item adds FIN (finalize multiply) and EMIT (result load), and EMIT
// waits while a result is held; the output register frees the hash chain when not stalled
// sync active-low reset: seed to its default, running hash to zero, no beat held
`default_nettype none

module murmur2_stream_hash import mmh_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_data_word,
    input  wire logic [2:0]  i_byte_count,
    input  wire logic        i_is_first,
    input  wire logic        i_is_last,
    input  wire logic [31:0] i_key_length,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_hash_value
);

    t_cmd cmd;

    mmh_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_byte_count (i_byte_count),
        .i_is_last    (i_is_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cmd        (cmd)
    );

    mmh_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_is_first   (i_is_first),
        .i_key_length (i_key_length),
        .o_hash_value (o_hash_value)
    );

    // an emit always produces a result beat
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.op == OP_EMIT |=> o_out_valid)
        else $error("emit without result beat");

    // finalize is followed by the emit step
    a_fin_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.op == OP_FIN |=> (cmd.op == OP_EMIT || (o_out_valid && !i_out_ready)))
        else $error("finalize not followed by emit");

    // no datapath step runs while input is open
    a_idle_no_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> cmd.op == OP_NONE)
        else $error("datapath busy while accepting");

    // new result only replaces a taken one
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> cmd.op != OP_EMIT)
        else $error("result overwritten");

endmodule

`default_nettype wire

// File: sim/murmur2_stream_hash_checker.sv
// murmur2_stream_hash_checker: watches the input, config and result channels,
// predicts each finalized hash and compares it with what the block emits
// depends on mmh_pkg for the hash constants and the reset seed
module murmur2_stream_hash_checker import mmh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_is_first,
    input  logic        i_is_last,
    input  logic [31:0] i_key_length,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_hash_value,
    output int unsigned o_fail_count,
    output int unsigned o_pending,
    output int unsigned o_hash_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] seed_q;
    logic [31:0] chain_q;
    logic [31:0] chain_next;
    logic [31:0] hash_want;
    logic [31:0] hash_expected[$];
    int unsigned fail_total = 0;
    int unsigned hash_total = 0;

    function automatic logic [31:0] scramble_word(input logic [31:0] k);
        logic [31:0] t;
        t = k * MixMult;
        t = t ^ (t >> MixShift);
        t = t * MixMult;
        return t;
    endfunction

    function automatic logic [31:0] avalanche(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> FinShiftA);
        t = t * MixMult;
        t = t ^ (t >> FinShiftB);
        return t;
    endfunction

    // one beat applied to the running chain, before any finalization
    function automatic logic [31:0] absorb_beat(input logic [31:0] chain,
                                                input logic [31:0] seed,
                                                input logic [31:0] word,
                                                input logic [2:0]  count,
                                                input logic        first,
                                                input logic [31:0] klen);
        logic [31:0] h;
        logic [31:0] mask;
        h = first ? (seed ^ klen) : chain;
        if (count >= 3'd4) begin
            // counts five to seven saturate to a full word
            h = (h * MixMult) ^ scramble_word(word);
        end else if (count != 3'd0) begin
            mask = (32'd1 << (count * 8)) - 32'd1;
            h = h ^ (word & mask);
            h = h * MixMult;
        end
        return h;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seed_q  = SeedReset;
            chain_q = 32'd0;
            hash_expected.delete();
        end else begin
            if (i_cfg_we)
                seed_q = i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                chain_next = absorb_beat(chain_q, seed_q, i_data_word, i_byte_count,
                                         i_is_first, i_key_length);
                if (i_is_last) begin
                    chain_next = avalanche(chain_next);
                    hash_expected.push_back(chain_next);
                end
                chain_q = chain_next;
            end
            if (i_out_valid && i_out_ready) begin
                hash_total++;
                if (hash_expected.size() == 0) begin
                    $error("hash_value: expected none, actual %08h", i_hash_value);
                    fail_total++;
                end else begin
                    hash_want = hash_expected.pop_front();
                    if (i_hash_value !== hash_want) begin
                        $error("hash_value: expected %08h, actual %08h",
                               hash_want, i_hash_value);
                        fail_total++;
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= hash_expected.size();
        o_hash_count <= hash_total;
    end

endmodule

// File: sim/testbench.sv
// testbench: drives keys and seed writes into murmur2_stream_hash with random
// idling on both channels; checking is done by murmur2_stream_hash_checker
// depends on mmh_pkg, murmur2_stream_hash and murmur2_stream_hash_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit   = 200000;
    localparam int unsigned HoldCycles   = 300;
    localparam int unsigned SettleCycles = 12;
    localparam int unsigned DrainCycles  = 24;
    localparam int unsigned PhaseBeats   = 200;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [31:0] cfg_data   = 32'd0;
    logic        in_valid   = 1'b0;
    logic [31:0] data_word  = 32'd0;
    logic [2:0]  byte_count = 3'd0;
    logic        is_first   = 1'b0;
    logic        is_last    = 1'b0;
    logic [31:0] key_length = 32'd0;
    logic        out_ready  = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [31:0] hash_value;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned hash_count;
    int unsigned cycle_count  = 0;
    int unsigned beats_sent   = 0;
    int unsigned seed_writes  = 0;
    bit          in_gaps      = 1'b1;
    bit          out_gaps     = 1'b1;
    bit          hold_req     = 1'b0;
    bit          hold_done    = 1'b0;

    murmur2_stream_hash i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_data_word  (data_word),
        .i_byte_count (byte_count),
        .i_is_first   (is_first),
        .i_is_last    (is_last),
        .i_key_length (key_length),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_hash_value (hash_value)
    );

    murmur2_stream_hash_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_data_word  (data_word),
        .i_byte_count (byte_count),
        .i_is_first   (is_first),
        .i_is_last    (is_last),
        .i_key_length (key_length),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_hash_value (hash_value),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_hash_count (hash_count)
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off so the block backs up
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                out_ready <= 1'b0;
                repeat (HoldCycles - 1) @(posedge clk);
                hold_done = 1'b1;
            end else if (out_gaps && $urandom_range(0, 6) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_beat(input logic [31:0] word, input logic [2:0] count,
                             input logic first, input logic last,
                             input logic [31:0] klen);
        if (in_gaps && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_word  <= word;
        byte_count <= count;
        is_first   <= first;
        is_last    <= last;
        key_length <= klen;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
    endtask

    // drop valid and wait until every hash is out and the chain has settled
    task automatic wait_idle(input int unsigned settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        wait_idle(SettleCycles);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        seed_writes++;
    endtask

    // mostly well-formed keys with random bytes; the rest are stray beats
    // and keys cut off before their last beat
    task automatic send_random_key();
        int unsigned len;
        int unsigned nfull;
        int unsigned nbeats;
        logic [2:0]  tail;
        logic [2:0]  count;
        logic [31:0] klen;
        logic        close_empty;
        logic        cut_short;
        if ($urandom_range(0, 9) >= 7) begin
            count = 3'($urandom_range(0, 7));
            send_beat($urandom, count, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), $urandom);
            return;
        end
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 64) : $urandom_range(0, 24);
        nfull = len / 4;
        tail = 3'(len % 4);
        close_empty = (tail == 3'd0) && (nfull == 0 || $urandom_range(0, 1) == 1);
        nbeats = nfull + ((tail != 3'd0 || close_empty) ? 1 : 0);
        cut_short = ($urandom_range(0, 11) == 0);
        klen = ($urandom_range(0, 19) == 0) ? $urandom : len;
        for (int i = 0; i < nbeats; i++) begin
            count = (i < nfull) ? 3'd4 : tail;
            send_beat($urandom, count, i == 0, (i == nbeats - 1) && !cut_short, klen);
        end
    endtask

    task automatic run_phase(input int unsigned beats, input bit with_hold);
        int unsigned goal;
        int unsigned hold_at;
        goal = beats_sent + beats;
        hold_at = beats_sent + 60;
        while (beats_sent < goal) begin
            if (with_hold && !hold_req && beats_sent >= hold_at)
                hold_req = 1'b1;
            send_random_key();
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // chain is zero after reset: no first beat, nothing but finalization
        send_beat(32'h0000_0000, 3'd0, 1'b0, 1'b1, 32'd0);
        // empty key
        send_beat(32'hdead_beef, 3'd0, 1'b1, 1'b1, 32'd0);
        // tails of one to three bytes, junk above the count
        send_beat(32'hffff_ffff, 3'd1, 1'b1, 1'b1, 32'd1);
        send_beat(32'h5a5a_a5a5, 3'd2, 1'b1, 1'b1, 32'd2);
        send_beat(32'hffff_ffff, 3'd3, 1'b1, 1'b1, 32'd3);
        // single full word closing the key
        send_beat(32'hffff_ffff, 3'd4, 1'b1, 1'b1, 32'd4);
        send_beat(32'h0000_0000, 3'd4, 1'b1, 1'b1, 32'd4);
        // two words then an empty closing beat
        send_beat(32'h0403_0201, 3'd4, 1'b1, 1'b0, 32'd8);
        send_beat(32'h0807_0605, 3'd4, 1'b0, 1'b0, 32'd8);
        send_beat(32'h0000_0000, 3'd0, 1'b0, 1'b1, 32'd8);
        // counts above four saturate to a full word
        send_beat(32'h1234_5678, 3'd5, 1'b1, 1'b0, 32'd12);
        send_beat(32'h9abc_def0, 3'd6, 1'b0, 1'b0, 32'd12);
        send_beat(32'h0f1e_2d3c, 3'd7, 1'b0, 1'b1, 32'd12);
        // partial word in the middle of a key
        send_beat(32'haabb_ccdd, 3'd2, 1'b1, 1'b0, 32'd9);
        send_beat(32'h1122_3344, 3'd4, 1'b0, 1'b0, 32'd9);
        send_beat(32'hffee_ddcc, 3'd3, 1'b0, 1'b1, 32'd9);
        // keep hashing from the last emitted value
        send_beat(32'hcafe_f00d, 3'd4, 1'b0, 1'b1, 32'd0);
        // length field unrelated to the bytes delivered
        send_beat(32'hffff_ffff, 3'd4, 1'b1, 1'b1, 32'hffff_ffff);
        send_beat(32'h8000_0001, 3'd3, 1'b1, 1'b1, 32'h8000_0000);
        // a second first beat restarts the chain
        send_beat(32'h0000_0001, 3'd4, 1'b1, 1'b0, 32'd4);
        send_beat(32'h0000_0002, 3'd1, 1'b1, 1'b1, 32'd1);
        // empty beat with no flags changes nothing
        send_beat(32'hffff_ffff, 3'd0, 1'b0, 1'b0, 32'hffff_ffff);
        send_beat(32'h0000_0000, 3'd2, 1'b0, 1'b1, 32'd0);

        write_seed(32'h0000_0000);
        run_phase(PhaseBeats, 1'b1);
        write_seed(32'hffff_ffff);
        run_phase(PhaseBeats, 1'b0);
        write_seed($urandom);
        run_phase(PhaseBeats, 1'b0);
        write_seed($urandom);
        in_gaps  = 1'b0;
        out_gaps = 1'b0;
        run_phase(PhaseBeats, 1'b0);

        wait_idle(DrainCycles);
        $display("sent %0d beats, checked %0d hashes under %0d seed settings",
                 beats_sent, hash_count, seed_writes + 1);
        $display("long result hold-off of %0d cycles with the input backed up", HoldCycles);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("%0d mismatches, %0d hashes never seen", fail_count, pending);
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// File: murmur2_stream_hash.f
hw/rtl/mmh_pkg.sv
hw/rtl/mmh_dpath.sv
hw/rtl/mmh_ctrl.sv
hw/rtl/murmur2_stream_hash.sv
sim/murmur2_stream_hash_checker.sv
sim/testbench.sv
